// File: src/bfo_pkg.sv
// Shared types and constants for the bucket fill block.
`timescale 1ns / 1ps
package bfo_pkg;

  // Payload widths of the item channels and configuration registers
  localparam int IDX_W    = 10;
  localparam int NONCE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int WASTE_W  = 16;
  localparam int FBC_W    = 11;
  localparam int RPB_W    = 5;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic REG_BUCKETS = 1'b0;
  localparam logic REG_RECORDS = 1'b1;

  localparam logic [FBC_W-1:0] BUCKETS_RST = FBC_W'(1024);
  localparam logic [RPB_W-1:0] RECORDS_RST = RPB_W'(16);

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_STORED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

  localparam logic [WASTE_W-1:0] WASTE_MAX = '1;
  localparam logic [FBC_W-1:0]   FBC_MAX   = '1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE
  } bfo_state_e;

  typedef struct packed {
    logic clr_we;
    logic accept;
    logic update;
  } bfo_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } bfo_sts_t;

endpackage

// File: src/bfo_if.sv
// Item channel interfaces: input records and results.
`timescale 1ns / 1ps
interface bfo_in_if;
  logic                         valid;
  logic                         ready;
  logic [bfo_pkg::IDX_W-1:0]    bucket_index;
  logic [bfo_pkg::NONCE_W-1:0]  nonce;

  modport source (output valid, bucket_index, nonce, input ready);
  modport sink (input valid, bucket_index, nonce, output ready);
endinterface

interface bfo_out_if;
  logic                          valid;
  logic                          ready;
  logic [bfo_pkg::STATUS_W-1:0]  status;
  logic [bfo_pkg::SLOT_W-1:0]    slot;
  logic [bfo_pkg::WASTE_W-1:0]   bucket_waste;
  logic [bfo_pkg::FBC_W-1:0]     full_bucket_count;
  logic                          all_full;

  modport source (output valid, status, slot, bucket_waste, full_bucket_count, all_full,
                  input ready);
  modport sink (input valid, status, slot, bucket_waste, full_bucket_count, all_full,
                output ready);
endinterface

// File: src/bucket_fill_with_overflow_count.sv
// Top level: bucketed record table with per-bucket overflow counting.
`timescale 1ns / 1ps
// Each input item names a bucket and carries a nonce; each yields one result item.
// On accept the bucket's state word (fill, full mark, waste count) is read
// into a register from a single-port-write bucket memory; the update, which
// waits until the result register is free, writes it back, stores the nonce
// and loads the result register. A new item is taken once the update is done,
// even while the previous result still waits in the result register. After
// reset a clearing pass writes every bucket state word, and no item is accepted
// until it ends; configuration writes are taken at any time.
module bucket_fill_with_overflow_count #(
  parameter int MAX_BUCKETS = 1024,
  parameter int MAX_RECORDS = 16,
  parameter int NONCE_BYTES = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfo_pkg::APB_AW-1:0]  paddr,
  input  logic [bfo_pkg::APB_DW-1:0]  pwdata,
  output logic [bfo_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  bfo_in_if.sink                      in_if,
  bfo_out_if.source                   out_if
);

  logic [bfo_pkg::FBC_W-1:0] buckets_in_use;
  logic [bfo_pkg::RPB_W-1:0] records_per_bucket;
  bfo_pkg::bfo_cmd_t         cmd;
  bfo_pkg::bfo_sts_t         sts;
  logic                      in_ready;

  bfo_regs u_regs (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .buckets_in_use_o     (buckets_in_use),
    .records_per_bucket_o (records_per_bucket)
  );

  bfo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bfo_dp #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .MAX_RECORDS (MAX_RECORDS),
    .NONCE_BYTES (NONCE_BYTES)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .bucket_index_i       (in_if.bucket_index),
    .nonce_i              (in_if.nonce),
    .buckets_in_use_i     (buckets_in_use),
    .records_per_bucket_i (records_per_bucket),
    .out_ready_i          (out_if.ready),
    .out_valid_o          (out_if.valid),
    .status_o             (out_if.status),
    .slot_o               (out_if.slot),
    .bucket_waste_o       (out_if.bucket_waste),
    .full_bucket_count_o  (out_if.full_bucket_count),
    .all_full_o           (out_if.all_full)
  );

  assign in_if.ready = in_ready;

endmodule

// File: src/bfo_regs.sv
// APB configuration registers: buckets in use and records per bucket.
`timescale 1ns / 1ps
module bfo_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfo_pkg::APB_AW-1:0]  paddr,
  input  logic [bfo_pkg::APB_DW-1:0]  pwdata,
  output logic [bfo_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [bfo_pkg::FBC_W-1:0]   buckets_in_use_o,
  output logic [bfo_pkg::RPB_W-1:0]   records_per_bucket_o
);

  logic [bfo_pkg::FBC_W-1:0] buckets_q;
  logic [bfo_pkg::RPB_W-1:0] records_q;
  logic                      wr_en;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buckets_q <= bfo_pkg::BUCKETS_RST;
      records_q <= bfo_pkg::RECORDS_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        bfo_pkg::REG_BUCKETS: buckets_q <= pwdata[bfo_pkg::FBC_W-1:0];
        bfo_pkg::REG_RECORDS: records_q <= pwdata[bfo_pkg::RPB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bfo_pkg::REG_BUCKETS: prdata = bfo_pkg::APB_DW'(buckets_q);
      bfo_pkg::REG_RECORDS: prdata = bfo_pkg::APB_DW'(records_q);
      default:              prdata = '0;
    endcase
  end

  assign buckets_in_use_o     = buckets_q;
  assign records_per_bucket_o = records_q;

endmodule

// File: src/bfo_ctrl.sv
// Controller: clearing sweep after reset, item accept and bucket update.
`timescale 1ns / 1ps
module bfo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bfo_pkg::bfo_sts_t sts_i,
  output bfo_pkg::bfo_cmd_t cmd_o
);

  bfo_pkg::bfo_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfo_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      bfo_pkg::S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_done) begin
          state_d = bfo_pkg::S_IDLE;
        end
      end
      bfo_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = bfo_pkg::S_UPDATE;
        end
      end
      bfo_pkg::S_UPDATE: begin
        // hold until the result register can take the item
        if (sts_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = bfo_pkg::S_IDLE;
        end
      end
      default: state_d = bfo_pkg::S_CLEAR;
    endcase
  end

endmodule

// File: src/bfo_dp.sv
// Datapath: bucket state memory, record store, full count and result register.
`timescale 1ns / 1ps
module bfo_dp #(
  parameter int MAX_BUCKETS = 1024,
  parameter int MAX_RECORDS = 16,
  parameter int NONCE_BYTES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfo_pkg::bfo_cmd_t             cmd_i,
  output bfo_pkg::bfo_sts_t             sts_o,
  input  logic [bfo_pkg::IDX_W-1:0]     bucket_index_i,
  input  logic [bfo_pkg::NONCE_W-1:0]   nonce_i,
  input  logic [bfo_pkg::FBC_W-1:0]     buckets_in_use_i,
  input  logic [bfo_pkg::RPB_W-1:0]     records_per_bucket_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [bfo_pkg::STATUS_W-1:0]  status_o,
  output logic [bfo_pkg::SLOT_W-1:0]    slot_o,
  output logic [bfo_pkg::WASTE_W-1:0]   bucket_waste_o,
  output logic [bfo_pkg::FBC_W-1:0]     full_bucket_count_o,
  output logic                          all_full_o
);

  localparam int BW   = $clog2(MAX_BUCKETS);
  localparam int FW   = $clog2(MAX_RECORDS + 1);
  localparam int CW   = (FW > bfo_pkg::RPB_W) ? FW : bfo_pkg::RPB_W;
  localparam int WW   = bfo_pkg::WASTE_W + 1 + FW;
  localparam int RECS = MAX_BUCKETS * MAX_RECORDS;
  localparam int RA   = $clog2(RECS);
  localparam int NB   = (NONCE_BYTES * 8 > bfo_pkg::NONCE_W) ? bfo_pkg::NONCE_W
                                                              : NONCE_BYTES * 8;
  localparam int XW   = 17;

  // Bucket state word: {waste, full mark, fill}
  logic [WW-1:0] bucket_mem [MAX_BUCKETS];
  logic [NB-1:0] record_mem [RECS];

  logic [WW-1:0]              rd_q;
  logic [BW-1:0]              clr_addr_q;
  logic [BW-1:0]              idx_q;
  logic [NB-1:0]              nonce_q;
  logic                       in_range_q;
  logic [bfo_pkg::FBC_W-1:0]  fbc_q, fbc_d;

  logic                         out_valid_q;
  logic [bfo_pkg::STATUS_W-1:0] status_q;
  logic [bfo_pkg::SLOT_W-1:0]   slot_q;
  logic [bfo_pkg::WASTE_W-1:0]  waste_q;
  logic [bfo_pkg::FBC_W-1:0]    fbc_out_q;
  logic                         all_full_q;

  logic [XW-1:0]              idx_ext;
  logic                       in_range;
  logic [FW-1:0]              rd_fill;
  logic                       rd_mark;
  logic [bfo_pkg::WASTE_W-1:0] rd_waste;
  logic [CW-1:0]              cap;
  logic [CW-1:0]              rpb_ext;
  logic                       stored;
  logic [FW-1:0]              fill_n;
  logic                       mark_n;
  logic [bfo_pkg::WASTE_W-1:0] waste_n;
  logic [bfo_pkg::STATUS_W-1:0] status_n;
  logic [bfo_pkg::WASTE_W-1:0] waste_out;
  logic                       bm_we;
  logic [BW-1:0]              bm_wa;
  logic [WW-1:0]              bm_wd;
  logic                       rec_we;
  logic [RA-1:0]              rec_wa;

  assign idx_ext  = XW'(bucket_index_i);
  assign in_range = (idx_ext < XW'(MAX_BUCKETS)) &&
                    (bfo_pkg::FBC_W'(bucket_index_i) < buckets_in_use_i);

  assign rd_fill  = rd_q[FW-1:0];
  assign rd_mark  = rd_q[FW];
  assign rd_waste = rd_q[WW-1:FW+1];

  // capacity is the register clipped to the slots a bucket has
  assign rpb_ext = CW'(records_per_bucket_i);
  assign cap     = (rpb_ext > CW'(MAX_RECORDS)) ? CW'(MAX_RECORDS) : rpb_ext;
  assign stored  = CW'(rd_fill) < cap;

  always_comb begin
    fbc_d     = fbc_q;
    fill_n    = rd_fill + FW'(1);
    mark_n    = rd_mark;
    waste_n   = rd_waste;
    status_n  = bfo_pkg::ST_STORED;
    if (!in_range_q) begin
      status_n = bfo_pkg::ST_RANGE;
    end else if (!stored) begin
      status_n = bfo_pkg::ST_OVERFLOW;
      fill_n   = FW'(cap);
      mark_n   = 1'b1;
      if (!rd_mark && fbc_q != bfo_pkg::FBC_MAX) begin
        fbc_d = fbc_q + bfo_pkg::FBC_W'(1);
      end
      if (rd_waste != bfo_pkg::WASTE_MAX) begin
        waste_n = rd_waste + bfo_pkg::WASTE_W'(1);
      end
    end
    waste_out = in_range_q ? waste_n : '0;
  end

  assign bm_we  = cmd_i.clr_we || (cmd_i.update && in_range_q);
  assign bm_wa  = cmd_i.clr_we ? clr_addr_q : idx_q;
  assign bm_wd  = cmd_i.clr_we ? '0 : {waste_n, mark_n, fill_n};
  assign rec_we = cmd_i.update && in_range_q && stored;
  assign rec_wa = RA'(idx_q) * RA'(MAX_RECORDS) + RA'(rd_fill);

  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bucket_mem[bm_wa] <= bm_wd;
    end
    if (cmd_i.accept) begin
      rd_q <= bucket_mem[idx_ext[BW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      record_mem[rec_wa] <= nonce_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q      <= idx_ext[BW-1:0];
      nonce_q    <= nonce_i[NB-1:0];
      in_range_q <= in_range;
    end
    if (cmd_i.update) begin
      status_q   <= status_n;
      slot_q     <= (status_n == bfo_pkg::ST_STORED) ? bfo_pkg::SLOT_W'(rd_fill) : '0;
      waste_q    <= waste_out;
      fbc_out_q  <= fbc_d;
      all_full_q <= fbc_d >= buckets_in_use_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      fbc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_we) begin
        clr_addr_q <= clr_addr_q + BW'(1);
      end
      if (cmd_i.update) begin
        fbc_q <= fbc_d;
      end
      if (cmd_i.update) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_done = clr_addr_q == BW'(MAX_BUCKETS - 1);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign slot_o              = slot_q;
  assign bucket_waste_o      = waste_q;
  assign full_bucket_count_o = fbc_out_q;
  assign all_full_o          = all_full_q;

endmodule
